// ===== hw/rtl/rms_level_meter_smoothed_assert.svh =====
// ----------------------------------------------------------------------------
// RMS level meter assertion macros
// Short forms for the concurrent checks used in the meter RTL.
// ----------------------------------------------------------------------------
`ifndef RMS_LEVEL_METER_SMOOTHED_ASSERT_SVH
`define RMS_LEVEL_METER_SMOOTHED_ASSERT_SVH

// same-cycle implication
`define RMSLM_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rms level meter: assertion failed");

// next-cycle implication
`define RMSLM_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rms level meter: assertion failed");

`endif

// ===== hw/rtl/rmslm_pkg.sv =====
// ----------------------------------------------------------------------------
// RMS level meter package
// Widths, register codes, reset values and sample helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package rmslm_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int MAG_W      = 17;
   localparam int LEVEL_W    = 16;
   localparam int SCALED_W   = 12;
   localparam int WEIGHT_W   = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;
   localparam int SUM_W      = 40;
   localparam int ACCUM_W    = 24;
   localparam int MUL_A_W    = 24;
   localparam int MUL_B_W    = 17;
   localparam int MUL_P_W    = MUL_A_W + MUL_B_W;

   localparam int MAX_PAIRS_DEF = 1024;

   localparam logic [WEIGHT_W-1:0] WEIGHT_RST     = 16'd4588;
   localparam logic [WEIGHT_W-1:0] FULL_SCALE_RST = 16'd11141;
   localparam logic [SCALED_W-1:0] SCALED_MAX_RST = 12'd700;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WEIGHT     = 2'd0,
      CSR_FULL_SCALE = 2'd1,
      CSR_SCALED_MAX = 2'd2
   } csr_index_type;

   // magnitude of a Q1.15 sample; -1.0 gives 0x8000
   function automatic logic [MAG_W-1:0] sample_mag(input logic [SAMPLE_W-1:0] s);
      logic [MAG_W-1:0] ext;
      ext = {1'b0, s};
      return s[SAMPLE_W-1] ? (17'h10000 - ext) : ext;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rmslm_if.sv =====
// ----------------------------------------------------------------------------
// RMS level meter channels
// Valid/ready channels for sample pairs, level results and register writes.
// ----------------------------------------------------------------------------
`default_nettype none

interface rmslm_req_if import rmslm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] left_sample;
   logic signed [SAMPLE_W-1:0] right_sample;
   logic                       last_in_buffer;

   modport source (output valid, left_sample, right_sample, last_in_buffer,
                   input ready);
   modport sink   (input valid, left_sample, right_sample, last_in_buffer,
                   output ready);
endinterface

interface rmslm_rsp_if import rmslm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [LEVEL_W-1:0]  smoothed_level;
   logic [SCALED_W-1:0] scaled_level;
   logic                pairs_dropped;

   modport source (output valid, smoothed_level, scaled_level, pairs_dropped,
                   input ready);
   modport sink   (input valid, smoothed_level, scaled_level, pairs_dropped,
                   output ready);
endinterface

interface rmslm_csr_if import rmslm_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rmslm_mul.sv =====
// ----------------------------------------------------------------------------
// RMS level meter multiplier
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module rmslm_mul import rmslm_pkg::*; (
   input  wire logic               clock,
   input  wire logic [MUL_A_W-1:0] op_a,
   input  wire logic [MUL_B_W-1:0] op_b,
   output logic      [MUL_P_W-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= MUL_P_W'(op_a) * MUL_P_W'(op_b);
   end

endmodule

`default_nettype wire

// ===== hw/rtl/rms_level_meter_smoothed.sv =====
// ----------------------------------------------------------------------------
// Smoothed RMS level meter
// Sum of squares over a buffer of stereo pairs, mean, square root, one-pole
// smoother and a clamped linear rescale, all on one multiplier and one
// shared compare/subtract unit.
// ----------------------------------------------------------------------------
// A pair that does not close a buffer holds ready low while it is squared
//   and summed; ready rises again once the meter is back in idle.
// A closing pair runs the mean divide (41 steps), the root (16 steps),
//   the smoother and, unless the level clamps, the scale divide (28 steps)
//   before its result goes on rsp. No new pair is taken until the last is
//   done; a close waits while an earlier result still sits in the register.
// Reset: synchronous, active high; clears state and result valid, loads defaults.
`default_nettype none

`include "rms_level_meter_smoothed_assert.svh"

module rms_level_meter_smoothed import rmslm_pkg::*; #(
   parameter int MAX_PAIRS = MAX_PAIRS_DEF
) (
   input wire logic   clock,
   input wire logic   reset,
   rmslm_req_if.sink  req_chan,
   rmslm_rsp_if.source rsp_chan,
   rmslm_csr_if.sink  csr_chan
);

   localparam int CNT_W  = $clog2(MAX_PAIRS + 1);
   localparam int DIV_W  = 16;            // divisor: pair count or full scale
   localparam int NUM_W  = SUM_W + 1;     // dividend / quotient shifter
   localparam int SUB_W  = 33;            // shared subtractor operand width
   localparam int SQ_W   = 32;            // root operand width
   localparam int STEP_W = 6;
   localparam int ACC_W  = 42;            // smoother sum

   localparam logic [STEP_W-1:0] MEAN_STEPS  = STEP_W'(NUM_W);
   localparam logic [STEP_W-1:0] SCALE_STEPS = 6'd28;
   localparam logic [STEP_W-1:0] ROOT_STEPS  = 6'd16;
   localparam logic [SQ_W-1:0]   ROOT_BIT0   = 32'h4000_0000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SQ_L,
      ST_SQ_R,
      ST_SQ_ACC,
      ST_MEAN_INIT,
      ST_DIV,
      ST_SQRT,
      ST_SM_A,
      ST_SM_B,
      ST_SM_C,
      ST_SM_D,
      ST_SC_CHK,
      ST_SC_MUL,
      ST_SC_DONE,
      ST_EMIT
   } state_type;

   state_type state_ff;

   // configuration
   logic [WEIGHT_W-1:0] weight_ff;
   logic [LEVEL_W-1:0]  full_ff;
   logic [SCALED_W-1:0] smax_ff;

   // buffer state
   logic [SUM_W-1:0]   sum_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               ovf_ff;
   logic [ACCUM_W-1:0] level_ff;

   // current item
   logic [SAMPLE_W-1:0] left_ff;
   logic [SAMPLE_W-1:0] right_ff;
   logic                last_ff;
   logic                acc_en_ff;

   // iteration registers
   logic [NUM_W-1:0]  num_ff;     // dividend in, quotient out; root operand
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  divisor_ff;
   logic [SQ_W-1:0]   res_ff;
   logic [SQ_W-1:0]   bit_ff;
   logic [STEP_W-1:0] step_ff;
   logic              scale_pass_ff;
   logic [ACC_W-1:0]  acc_ff;
   logic [LEVEL_W-1:0]  lvl_val_ff;
   logic [SCALED_W-1:0] scaled_val_ff;

   // result register
   logic                rsp_valid_ff;
   logic [LEVEL_W-1:0]  rsp_level_ff;
   logic [SCALED_W-1:0] rsp_scaled_ff;
   logic                rsp_drop_ff;

   logic req_fire;
   logic rsp_fire;
   logic out_free;

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.smoothed_level = rsp_level_ff;
   assign rsp_chan.scaled_level   = rsp_scaled_ff;
   assign rsp_chan.pairs_dropped  = rsp_drop_ff;
   assign rsp_fire = rsp_valid_ff && rsp_chan.ready;
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // ---------------------------------------------------------------------
   // Shared multiplier: squares, smoother terms, scale product
   // ---------------------------------------------------------------------
   logic [MUL_A_W-1:0] mul_a;
   logic [MUL_B_W-1:0] mul_b;
   logic [MUL_P_W-1:0] mul_prod;
   logic [MAG_W-1:0]   mag_l;
   logic [MAG_W-1:0]   mag_r;
   logic [24:0]        lvl_round;
   logic [16:0]        lvl_full;

   assign mag_l     = sample_mag(left_ff);
   assign mag_r     = sample_mag(right_ff);
   // smoothed level rounded half up to Q0.16; can reach 17 bits
   assign lvl_round = {1'b0, level_ff} + 25'd128;
   assign lvl_full  = lvl_round[24:8];

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_SQ_L: begin
            mul_a = MUL_A_W'(mag_l);
            mul_b = mag_l;
         end
         ST_SQ_R: begin
            mul_a = MUL_A_W'(mag_r);
            mul_b = mag_r;
         end
         ST_SM_A: begin
            mul_a = level_ff;
            mul_b = 17'h10000 - {1'b0, weight_ff};   // 1 - a
         end
         ST_SM_B: begin
            mul_a = {res_ff[15:0], 8'd0};            // rms in Q0.24
            mul_b = {1'b0, weight_ff};
         end
         ST_SC_CHK: begin
            mul_a = MUL_A_W'(lvl_full);
            mul_b = MUL_B_W'(smax_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   rmslm_mul u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (mul_prod)
   );

   // saturating add of the quarter square just out of the multiplier
   logic [SUM_W:0]   sum_wide;
   logic [SUM_W-1:0] sum_sat;

   assign sum_wide = {1'b0, sum_ff} + (SUM_W+1)'(mul_prod[30:2]);
   assign sum_sat  = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   // ---------------------------------------------------------------------
   // Shared compare/subtract: restoring divide step or root step
   // ---------------------------------------------------------------------
   logic [SUB_W-1:0] sub_a;
   logic [SUB_W-1:0] sub_b;
   logic [SUB_W:0]   sub_diff;
   logic             sub_ge;
   logic [SQ_W-1:0]  root_trial;

   assign root_trial = res_ff + bit_ff;

   always_comb begin
      if (state_ff == ST_SQRT) begin
         sub_a = {1'b0, num_ff[SQ_W-1:0]};
         sub_b = {1'b0, root_trial};
      end else begin
         sub_a = SUB_W'({rem_ff, num_ff[NUM_W-1]});
         sub_b = SUB_W'(divisor_ff);
      end
   end

   assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_ge   = !sub_diff[SUB_W];

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         weight_ff     <= WEIGHT_RST;
         full_ff       <= FULL_SCALE_RST;
         smax_ff       <= SCALED_MAX_RST;
         sum_ff        <= '0;
         count_ff      <= '0;
         ovf_ff        <= 1'b0;
         level_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         scale_pass_ff <= 1'b0;
         step_ff       <= '0;
      end else begin
         if (csr_chan.valid) begin
            case (csr_chan.index)
               CSR_WEIGHT:     weight_ff <= csr_chan.data;
               CSR_FULL_SCALE: full_ff   <= csr_chan.data;
               CSR_SCALED_MAX: smax_ff   <= csr_chan.data[SCALED_W-1:0];
               default: ;
            endcase
         end

         // in ST_EMIT the result register is reloaded below instead
         if (rsp_fire && state_ff != ST_EMIT) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  left_ff  <= req_chan.left_sample;
                  right_ff <= req_chan.right_sample;
                  last_ff  <= req_chan.last_in_buffer;
                  // a full buffer drops the pair but still honors its mark
                  if (count_ff < CNT_W'(MAX_PAIRS)) begin
                     acc_en_ff <= 1'b1;
                     count_ff  <= count_ff + 1'b1;
                  end else begin
                     acc_en_ff <= 1'b0;
                     ovf_ff    <= 1'b1;
                  end
                  state_ff <= ST_SQ_L;
               end
            end
            ST_SQ_L: begin
               state_ff <= ST_SQ_R;
            end
            ST_SQ_R: begin
               if (acc_en_ff) begin
                  sum_ff <= sum_sat;
               end
               state_ff <= ST_SQ_ACC;
            end
            ST_SQ_ACC: begin
               if (acc_en_ff) begin
                  sum_ff <= sum_sat;
               end
               state_ff <= last_ff ? ST_MEAN_INIT : ST_IDLE;
            end
            ST_MEAN_INIT: begin
               // mean = 2 * sum / pairs
               num_ff        <= {sum_ff, 1'b0};
               rem_ff        <= '0;
               divisor_ff    <= DIV_W'(count_ff);
               step_ff       <= MEAN_STEPS;
               scale_pass_ff <= 1'b0;
               state_ff      <= ST_DIV;
            end
            ST_DIV: begin
               num_ff <= {num_ff[NUM_W-2:0], sub_ge};
               rem_ff <= sub_ge ? sub_diff[DIV_W-1:0]
                                : {rem_ff[DIV_W-2:0], num_ff[NUM_W-1]};
               if (step_ff == 6'd1) begin
                  if (scale_pass_ff) begin
                     state_ff <= ST_SC_DONE;
                  end else begin
                     res_ff   <= '0;
                     bit_ff   <= ROOT_BIT0;
                     step_ff  <= ROOT_STEPS;
                     state_ff <= ST_SQRT;
                  end
               end else begin
                  step_ff <= step_ff - 1'b1;
               end
            end
            ST_SQRT: begin
               // mean fits 31 bits, so one bit pair per step from bit 30 down
               if (sub_ge) begin
                  num_ff[SQ_W-1:0] <= sub_diff[SQ_W-1:0];
                  res_ff           <= (res_ff >> 1) + bit_ff;
               end else begin
                  res_ff <= res_ff >> 1;
               end
               bit_ff  <= bit_ff >> 2;
               step_ff <= step_ff - 1'b1;
               if (step_ff == 6'd1) begin
                  state_ff <= ST_SM_A;
               end
            end
            ST_SM_A: begin
               state_ff <= ST_SM_B;
            end
            ST_SM_B: begin
               acc_ff   <= ACC_W'(mul_prod) + ACC_W'(32768);
               state_ff <= ST_SM_C;
            end
            ST_SM_C: begin
               acc_ff   <= acc_ff + ACC_W'(mul_prod);
               state_ff <= ST_SM_D;
            end
            ST_SM_D: begin
               level_ff <= acc_ff[39:16];
               state_ff <= ST_SC_CHK;
            end
            ST_SC_CHK: begin
               lvl_val_ff <= lvl_full[LEVEL_W-1:0];
               // at or above full scale (also full scale zero) clamps
               if (lvl_full >= {1'b0, full_ff}) begin
                  scaled_val_ff <= smax_ff;
                  state_ff      <= ST_EMIT;
               end else begin
                  state_ff <= ST_SC_MUL;
               end
            end
            ST_SC_MUL: begin
               // 28-bit product aligned to the top of the shifter
               num_ff        <= {mul_prod[27:0], 13'd0};
               rem_ff        <= '0;
               divisor_ff    <= full_ff;
               step_ff       <= SCALE_STEPS;
               scale_pass_ff <= 1'b1;
               state_ff      <= ST_DIV;
            end
            ST_SC_DONE: begin
               scaled_val_ff <= num_ff[SCALED_W-1:0];
               state_ff      <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_level_ff  <= lvl_val_ff;
                  rsp_scaled_ff <= scaled_val_ff;
                  rsp_drop_ff   <= ovf_ff;
                  sum_ff        <= '0;
                  count_ff      <= '0;
                  ovf_ff        <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
   `RMSLM_ASSERT_IMPL(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(MAX_PAIRS))
   `RMSLM_ASSERT_NEXT(a_full_sets_drop, clock, reset, req_fire && (count_ff == CNT_W'(MAX_PAIRS)), ovf_ff)
   `RMSLM_ASSERT_IMPL(a_scaled_clamp, clock, reset, rsp_valid_ff, rsp_scaled_ff <= smax_ff)
   `RMSLM_ASSERT_IMPL(a_level_range, clock, reset, rsp_valid_ff, rsp_level_ff <= 16'h8000)

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Smoothed RMS level meter testbench
// Streams stereo sample pairs through the meter in buffers of random length
// and checks every level result against a cycle-free prediction of the
// sum of squares, mean, root, smoother and clamped rescale. Register
// settings change between phases, extremes and a zero full scale included.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
   import rmslm_pkg::*;

   localparam int          BUF_PAIRS   = MAX_PAIRS_DEF;
   localparam int          PHASES      = 6;
   localparam int          RAND_ITEMS  = 70;       // random pairs per phase
   localparam int          IDLE_CYCLES = 120;
   localparam int          HOLD_AT     = 40;       // pairs sent before the long stall
   localparam int          HOLD_CYCLES = 600;
   localparam int          CYCLE_LIMIT = 1000000;
   localparam logic [SUM_W-1:0] SUM_MAX = '1;

   // one stereo pair as offered on req; drain holds it back until every
   // level result so far has come out
   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       closes;
      logic                       drain;
   } pair_type;

   typedef struct {
      logic [LEVEL_W-1:0]  smoothed;
      logic [SCALED_W-1:0] scaled;
      logic                dropped;
   } level_rec_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rmslm_req_if req_chan ();
   rmslm_rsp_if rsp_chan ();
   rmslm_csr_if csr_chan ();

   rms_level_meter_smoothed #(
      .MAX_PAIRS (BUF_PAIRS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_chan (csr_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------------
   // Meter prediction: register copies and buffer state
   // ---------------------------------------------------------------------
   logic [WEIGHT_W-1:0] cfg_weight     = WEIGHT_RST;
   logic [WEIGHT_W-1:0] cfg_full_scale = FULL_SCALE_RST;
   logic [SCALED_W-1:0] cfg_scaled_max = SCALED_MAX_RST;

   logic [SUM_W-1:0]    sq_sum       = '0;
   int unsigned         pairs_in_buf = 0;
   logic                dropped_flag = 1'b0;
   logic [ACCUM_W-1:0]  lvl_accum    = '0;

   level_rec_type level_expect[$];   // levels still owed by the meter
   pair_type      pending_pairs[$];  // pairs not yet offered

   // square of the halved sample, units of 2^-30
   function automatic logic [63:0] quarter_sq(input logic signed [SAMPLE_W-1:0] s);
      longint v;
      v = s;
      if (v < 0)
         v = -v;
      return 64'(v * v) >> 2;
   endfunction

   function automatic logic [31:0] root_floor(input logic [63:0] x);
      logic [63:0] root, trial;
      int          k;
      root = '0;
      for (k = 31; k >= 0; k--) begin
         trial = root | (64'd1 << k);
         if (trial * trial <= x)
            root = trial;
      end
      return root[31:0];
   endfunction

   // fold one accepted pair into the buffer; a closing pair yields a level
   function automatic void advance_meter(input pair_type p);
      logic [63:0]   sum_next, mean, prod;
      logic [31:0]   rms;
      logic [16:0]   lvl;
      level_rec_type rec;
      if (pairs_in_buf < BUF_PAIRS) begin
         sum_next = 64'(sq_sum) + quarter_sq(p.left) + quarter_sq(p.right);
         sq_sum = (sum_next > 64'(SUM_MAX)) ? SUM_MAX : sum_next[SUM_W-1:0];
         pairs_in_buf++;
      end else begin
         // buffer full: pair is dropped but its close mark still counts
         dropped_flag = 1'b1;
      end
      if (!p.closes)
         return;

      mean = (64'(sq_sum) << 1) / 64'(pairs_in_buf);
      rms  = root_floor(mean);
      // one-pole smoother in Q0.24, weight a on the new value
      prod = 64'(lvl_accum) * (64'd65536 - 64'(cfg_weight))
           + 64'(cfg_weight) * (64'(rms) << 8) + 64'd32768;
      lvl_accum = prod[16 +: ACCUM_W];
      lvl = 17'((25'(lvl_accum) + 25'd128) >> 8);

      rec.smoothed = lvl[LEVEL_W-1:0];
      // clamp covers a zero full scale as well
      if (lvl >= 17'(cfg_full_scale))
         rec.scaled = cfg_scaled_max;
      else
         rec.scaled = SCALED_W'((64'(lvl) * 64'(cfg_scaled_max)) / 64'(cfg_full_scale));
      rec.dropped = dropped_flag;
      level_expect.insert(level_expect.size(), rec);

      sq_sum       = '0;
      pairs_in_buf = 0;
      dropped_flag = 1'b0;
   endfunction

   // ---------------------------------------------------------------------
   // Pair driver: offers pending pairs, predicts on each accepted item
   // ---------------------------------------------------------------------
   pair_type    cur_pair;
   int unsigned pair_gap    = 0;
   bit          pair_burst  = 1'b0;
   int unsigned pairs_sent  = 0;
   int unsigned closes_sent = 0;
   int unsigned levels_seen = 0;

   always @(posedge clock) begin : pair_driver
      int unsigned open_closes;
      if (reset) begin
         req_chan.valid <= 1'b0;
         pair_gap = 0;
      end else begin
         // counters are read before this edge's updates land, so the drain
         // test may run late but never early
         open_closes = closes_sent - levels_seen;
         if (req_chan.valid && req_chan.ready) begin
            advance_meter(cur_pair);
            pairs_sent <= pairs_sent + 1;
            if (cur_pair.closes) begin
               closes_sent <= closes_sent + 1;
               open_closes++;
            end
            // bursts with no idling now and then
            if ($urandom_range(0, 63) == 0)
               pair_burst = !pair_burst;
            pair_gap = pair_burst ? 0 : $urandom_range(0, 4);
         end
         if (!req_chan.valid || req_chan.ready) begin
            if (pair_gap != 0) begin
               pair_gap--;
               req_chan.valid <= 1'b0;
            end else if (pending_pairs.size() != 0 &&
                         (!pending_pairs[0].drain || open_closes == 0)) begin
               cur_pair = pending_pairs.pop_front();
               req_chan.left_sample    <= cur_pair.left;
               req_chan.right_sample   <= cur_pair.right;
               req_chan.last_in_buffer <= cur_pair.closes;
               req_chan.valid          <= 1'b1;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Long result stall: once, the receiver sits out HOLD_CYCLES while
   // pairs keep coming, so the result register fills and req backs up
   // ---------------------------------------------------------------------
   int unsigned hold_left  = 0;
   bit          hold_armed = 1'b1;

   always @(posedge clock) begin
      if (reset) begin
         hold_left  <= 0;
         hold_armed <= 1'b1;
      end else if (hold_armed && pairs_sent == HOLD_AT) begin
         hold_left  <= HOLD_CYCLES;
         hold_armed <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------------------------------------------------------------
   // Level monitor: random ready, field checks against the oldest level
   // ---------------------------------------------------------------------
   int unsigned rsp_stall   = 0;
   bit          rsp_burst   = 1'b0;
   int unsigned error_count = 0;

   always @(posedge clock) begin : level_monitor
      level_rec_type want;
      if (reset) begin
         rsp_chan.ready <= 1'b0;
         rsp_stall = 0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            levels_seen <= levels_seen + 1;
            if (level_expect.size() == 0) begin
               error_count++;
               if (error_count <= 10)
                  $display("unexpected level item: smoothed=%0d scaled=%0d dropped=%0d",
                           rsp_chan.smoothed_level, rsp_chan.scaled_level,
                           rsp_chan.pairs_dropped);
            end else begin
               want = level_expect.pop_front();
               if (rsp_chan.smoothed_level !== want.smoothed ||
                   rsp_chan.scaled_level   !== want.scaled   ||
                   rsp_chan.pairs_dropped  !== want.dropped) begin
                  error_count++;
                  if (error_count <= 10)
                     $display("level %0d mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                              levels_seen, want.smoothed, want.scaled, want.dropped,
                              rsp_chan.smoothed_level, rsp_chan.scaled_level,
                              rsp_chan.pairs_dropped);
               end
            end
            if ($urandom_range(0, 31) == 0)
               rsp_burst = !rsp_burst;
            rsp_stall = rsp_burst ? 0 : $urandom_range(0, 4);
         end
         // stall counts down whether or not a level is waiting, so ready
         // drops land on every phase of the close sequence
         if (hold_left != 0) begin
            rsp_chan.ready <= 1'b0;
         end else if (rsp_stall != 0) begin
            rsp_stall--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog
   // ---------------------------------------------------------------------
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d levels owed", cycle_count,
                  level_expect.size());
         $display("Verification failed");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------
   task automatic add_pair(input logic signed [SAMPLE_W-1:0] l,
                           input logic signed [SAMPLE_W-1:0] r,
                           input logic closes, input logic drain);
      pair_type p;
      p.left   = l;
      p.right  = r;
      p.closes = closes;
      p.drain  = drain;
      pending_pairs.insert(pending_pairs.size(), p);
   endtask

   // full-range value, an extreme, or a quieter signal for this buffer
   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int unsigned shift);
      logic signed [SAMPLE_W-1:0] raw;
      raw = SAMPLE_W'($urandom);
      case ($urandom_range(0, 19))
         0:       return 16'sh8000;
         1:       return 16'sh7fff;
         2:       return 16'sh0000;
         3:       return 16'shffff;
         default: return raw >>> shift;
      endcase
   endfunction

   task automatic add_buffer(input int unsigned len);
      int unsigned k, shift;
      shift = $urandom_range(0, 15);
      for (k = 1; k <= len; k++)
         add_pair(draw_sample(shift), draw_sample(shift), k == len,
                  $urandom_range(0, 299) == 0);
   endtask

   // mostly short buffers, some single pairs, a few longer ones
   task automatic add_random_buffers(input int unsigned n_items);
      int unsigned added, len, pick;
      added = 0;
      while (added < n_items) begin
         pick = $urandom_range(0, 99);
         if (pick < 15)
            len = 1;
         else if (pick < 90)
            len = $urandom_range(2, 12);
         else
            len = $urandom_range(13, 60);
         add_buffer(len);
         added += len;
      end
   endtask

   task automatic queue_phase(input int phase);
      @(negedge clock);
      case (phase)
         0: begin
            // sample extremes, one pair per buffer, then a short mixed one
            add_pair(16'sh8000, 16'sh8000, 1'b1, 1'b0);
            add_pair(16'sh7fff, 16'sh7fff, 1'b1, 1'b0);
            add_pair(16'sh0000, 16'sh0000, 1'b1, 1'b0);
            add_pair(16'sh8000, 16'sh7fff, 1'b1, 1'b0);
            add_pair(16'shffff, 16'sh0001, 1'b1, 1'b0);
            add_pair(16'sh0001, 16'shffff, 1'b0, 1'b0);
            add_pair(16'shfffe, 16'sh0002, 1'b0, 1'b0);
            add_pair(16'sh4000, 16'shc000, 1'b1, 1'b0);
            // sender waits for every level before this one
            add_pair(16'sh5555, 16'shaaaa, 1'b1, 1'b1);
            add_random_buffers(RAND_ITEMS);
         end
         1: begin
            // full weight: level follows rms, full-scale input clamps
            repeat (3) add_pair(16'sh8000, 16'sh8000, 1'b1, 1'b0);
            add_pair(16'sh0000, 16'sh0000, 1'b1, 1'b0);
            add_pair(16'sh7fff, 16'sh8000, 1'b1, 1'b0);
            add_random_buffers(RAND_ITEMS);
         end
         3: begin
            // zero full scale: every level clamps
            add_pair(16'sh3039, 16'shcfc7, 1'b1, 1'b0);
            add_pair(16'sh0000, 16'sh0000, 1'b1, 1'b0);
            add_random_buffers(RAND_ITEMS);
         end
         4: begin
            add_random_buffers(RAND_ITEMS);
            // one pair past a full buffer: dropped, its mark still closes
            add_buffer(BUF_PAIRS + 1);
         end
         default: add_random_buffers(RAND_ITEMS);
      endcase
   endtask

   // wait for an idle meter: all pairs taken, all levels back, then an
   // IDLE_CYCLES wait before any register write
   task automatic settle_meter();
      do
         @(negedge clock);
      while (pending_pairs.size() != 0 || req_chan.valid || closes_sent != levels_seen);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_chan.index <= idx;
      csr_chan.data  <= val;
      csr_chan.valid <= 1'b1;
      @(posedge clock);
      while (!csr_chan.ready)
         @(posedge clock);
      case (idx)
         CSR_WEIGHT:     cfg_weight     = val;
         CSR_FULL_SCALE: cfg_full_scale = val;
         CSR_SCALED_MAX: cfg_scaled_max = val[SCALED_W-1:0];
         default: ;
      endcase
      csr_chan.valid <= 1'b0;
   endtask

   // register settings per phase; scaled_max writes carry random upper bits
   task automatic configure(input int phase);
      case (phase)
         1: begin
            write_csr(CSR_WEIGHT, 16'hffff);
            write_csr(CSR_FULL_SCALE, 16'd1);
            write_csr(CSR_SCALED_MAX, {4'($urandom), 12'hfff});
         end
         2: begin
            // zero weight freezes the level
            write_csr(CSR_WEIGHT, 16'h0000);
            write_csr(CSR_FULL_SCALE, 16'hffff);
            write_csr(CSR_SCALED_MAX, {4'($urandom), 12'h000});
         end
         3: begin
            write_csr(CSR_WEIGHT, 16'h8000);
            write_csr(CSR_FULL_SCALE, 16'h0000);
            write_csr(CSR_SCALED_MAX, {4'($urandom), 12'($urandom)});
         end
         4: begin
            write_csr(CSR_SCALED_MAX, {4'($urandom), 12'($urandom)});
            write_csr(CSR_WEIGHT, 16'($urandom));
            write_csr(CSR_FULL_SCALE, 16'($urandom_range(1, 65535)));
         end
         default: begin
            // slow smoother against a mid full scale
            write_csr(CSR_WEIGHT, 16'($urandom_range(1, 255)));
            write_csr(CSR_FULL_SCALE, 16'h8000);
            write_csr(CSR_SCALED_MAX, {4'($urandom), 12'hfff});
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin : main_seq
      int phase;
      req_chan.valid          = 1'b0;
      req_chan.left_sample    = '0;
      req_chan.right_sample   = '0;
      req_chan.last_in_buffer = 1'b0;
      rsp_chan.ready          = 1'b0;
      csr_chan.valid          = 1'b0;
      csr_chan.index          = CSR_WEIGHT;
      csr_chan.data           = '0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // phase 0 runs on the reset defaults
      for (phase = 0; phase < PHASES; phase++) begin
         if (phase != 0) begin
            settle_meter();
            configure(phase);
         end
         queue_phase(phase);
      end
      settle_meter();

      if (level_expect.size() != 0)
         $display("%0d level items never arrived", level_expect.size());
      if (error_count == 0 && level_expect.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule
